### rtl/gbp_pkg.sv
// Shared types and constants of the gradient beam progress pixel generator.
package gbp_pkg;

  localparam int OP_W      = 2;
  localparam int COL_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 13;
  localparam int TRK_W     = 13;
  localparam int BW_W      = 13;
  localparam int STEP_W    = 8;
  localparam int SHIFT_W   = 5;
  localparam int POS_W     = 14;
  localparam int QUO_W     = 16;
  localparam int PIX_W     = 32;
  localparam int COMP_W    = 8;
  localparam int T_W       = QUO_W + 1;
  localparam int PROD_W    = T_W + 9;

  // operation codes
  localparam logic [OP_W-1:0] OP_PIXEL   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RSHIFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GSHIFT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BSHIFT  = 3'd6;

  // register reset values
  localparam logic [TRK_W-1:0]   TRACK_RST  = 13'd540;
  localparam logic [BW_W-1:0]    BW_RST     = 13'd180;
  localparam logic [STEP_W-1:0]  STEP_RST   = 8'd18;
  localparam logic               FORMAT_RST = 1'b1;
  localparam logic [SHIFT_W-1:0] RSHIFT_RST = 5'd16;
  localparam logic [SHIFT_W-1:0] GSHIFT_RST = 5'd8;
  localparam logic [SHIFT_W-1:0] BSHIFT_RST = 5'd0;
  localparam logic [POS_W-1:0]   BEAM_RST   = POS_W'(0) - POS_W'(BW_RST);

  // two-segment color ramp
  localparam logic [COMP_W-1:0] G_LO_BASE  = 8'd30;
  localparam logic [8:0]        G_LO_SLOPE = 9'd240;
  localparam logic [COMP_W-1:0] B_LO_BASE  = 8'd100;
  localparam logic [8:0]        B_LO_SLOPE = 9'd310;
  localparam logic [8:0]        R_HI_SLOPE = 9'd100;
  localparam logic [COMP_W-1:0] G_HI_BASE  = 8'd150;
  localparam logic [8:0]        G_HI_SLOPE = 9'd105;
  localparam logic [COMP_W-1:0] B_HI       = 8'd255;

  typedef struct packed {
    logic            start;
    logic [BW_W-1:0] dividend;
    logic [BW_W-1:0] divisor;
  } gbp_div_req_t;

endpackage

### rtl/gradient_beam_progress_pixel_gen.sv
// Top level of the gradient beam progress bar pixel generator.
// An in-beam pixel passes the bit-serial divider (16 quotient bits), then the
//   ramp registers and the pack register; every other word goes straight to
//   pack. No new word is taken until the last one leaves pack, and pack waits
//   while the output slot is still full.
// Reset (async, active low) restores the register defaults and puts the beam
//   start at minus the default beam width; no word is pending after reset.
module gradient_beam_progress_pixel_gen #(
  parameter int MAX_TRACK = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gbp_pkg::OP_W-1:0]        operation_i,
  input  logic [gbp_pkg::COL_W-1:0]       column_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gbp_pkg::PIX_W-1:0]       pixel_value_o,
  output logic                            inside_beam_o,
  // register writes
  input  logic                            cfg_we_i,
  input  logic [gbp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gbp_pkg::CFG_W-1:0]       cfg_data_i
);
  import gbp_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PACK = 2'd2;

  localparam logic [POS_W-1:0] TRACK_LIM = POS_W'(MAX_TRACK);

  // configuration
  logic [TRK_W-1:0]   track_q;
  logic [BW_W-1:0]    bw_q;
  logic [STEP_W-1:0]  step_q;
  logic               fmt_q;
  logic [SHIFT_W-1:0] rsh_q, gsh_q, bsh_q;

  // control
  logic [1:0]         state_q;
  logic [POS_W-1:0]   beam_q;
  logic               inside_q;
  logic               out_valid_q;
  logic [PIX_W-1:0]   pix_out_q;
  logic               inside_out_q;

  // ramp components
  logic [COMP_W-1:0]  r_q, g_q, b_q;
  logic [COMP_W-1:0]  r_d, g_d, b_d;

  logic               accept, out_free;
  logic [POS_W-1:0]   eff_track;
  logic signed [POS_W:0] beam_ext, dist_s, next_s;
  logic               in_beam, wrap;
  logic [POS_W-1:0]   neg_bw;
  gbp_div_req_t       div_req;
  logic               div_done;
  logic [QUO_W-1:0]   quot;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // beam window and tick arithmetic, signed parts in 15 bits
  always_comb begin
    eff_track = ({1'b0, track_q} > TRACK_LIM) ? TRACK_LIM : {1'b0, track_q};
    beam_ext  = $signed({beam_q[POS_W-1], beam_q});
    dist_s    = $signed({3'b000, column_i}) - beam_ext;
    in_beam   = ({2'b00, column_i} < eff_track) && !dist_s[POS_W] &&
                (dist_s < $signed({2'b00, bw_q}));
    next_s    = beam_ext + $signed({7'b0000000, step_q});
    wrap      = next_s > $signed({1'b0, eff_track});
    neg_bw    = POS_W'(0) - {1'b0, bw_q};
  end

  always_comb begin
    div_req.start    = accept && (operation_i == OP_PIXEL) && in_beam;
    div_req.dividend = dist_s[BW_W-1:0];
    div_req.divisor  = bw_q;
  end

  gbp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Ramp: t = 1 - q in Q1.16. Lower half runs dark to mid, upper half mid to
  // bright with u = 2t - 1. One constant product per component.
  logic [T_W-1:0]    t_val, u_val, a_val;
  logic              lo_seg;
  logic [8:0]        kg;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;

  always_comb begin
    t_val  = T_W'(18'h10000 - {2'b00, quot});
    lo_seg = !t_val[T_W-1] && !t_val[T_W-2];
    u_val  = T_W'({t_val, 1'b0} - 18'h10000);
    a_val  = lo_seg ? t_val : u_val;
    kg     = lo_seg ? G_LO_SLOPE : G_HI_SLOPE;
    prod_r = PROD_W'(a_val) * PROD_W'(R_HI_SLOPE);
    prod_g = PROD_W'(a_val) * PROD_W'(kg);
    prod_b = PROD_W'(a_val) * PROD_W'(B_LO_SLOPE);
    r_d    = lo_seg ? '0 : prod_r[QUO_W +: COMP_W];
    g_d    = (lo_seg ? G_LO_BASE : G_HI_BASE) + prod_g[QUO_W +: COMP_W];
    b_d    = lo_seg ? (B_LO_BASE + prod_b[QUO_W +: COMP_W]) : B_HI;
  end

  // packing: 5:6:5 or 8:8:8, each field shifted by its offset, bits past 32 lost
  logic [PIX_W-1:0] r32, g32, b32, pix_packed;

  always_comb begin
    r32 = fmt_q ? PIX_W'(r_q) : PIX_W'(r_q[7:3]);
    g32 = fmt_q ? PIX_W'(g_q) : PIX_W'(g_q[7:2]);
    b32 = fmt_q ? PIX_W'(b_q) : PIX_W'(b_q[7:3]);
    pix_packed = (r32 << rsh_q) | (g32 << gsh_q) | (b32 << bsh_q);
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
    if (state_q == S_PACK && out_free) begin
      pix_out_q    <= inside_q ? pix_packed : '0;
      inside_out_q <= inside_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q     <= TRACK_RST;
      bw_q        <= BW_RST;
      step_q      <= STEP_RST;
      fmt_q       <= FORMAT_RST;
      rsh_q       <= RSHIFT_RST;
      gsh_q       <= GSHIFT_RST;
      bsh_q       <= BSHIFT_RST;
      state_q     <= S_IDLE;
      beam_q      <= BEAM_RST;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TRACK:  track_q <= cfg_data_i[TRK_W-1:0];
          CFG_BEAM:   bw_q    <= cfg_data_i[BW_W-1:0];
          CFG_STEP:   step_q  <= cfg_data_i[STEP_W-1:0];
          CFG_FORMAT: fmt_q   <= cfg_data_i[0];
          CFG_RSHIFT: rsh_q   <= cfg_data_i[SHIFT_W-1:0];
          CFG_GSHIFT: gsh_q   <= cfg_data_i[SHIFT_W-1:0];
          CFG_BSHIFT: bsh_q   <= cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
      end

      // a new word loads only once the output slot is free
      if (state_q == S_PACK && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            inside_q <= div_req.start;
            state_q  <= div_req.start ? S_DIV : S_PACK;
            case (operation_i)
              OP_TICK:    beam_q <= wrap ? neg_bw : next_s[POS_W-1:0];
              OP_RESTART: beam_q <= neg_bw;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_PACK;
        end
        S_PACK: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pix_out_q;
  assign inside_beam_o = inside_out_q;

  a_div_only_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == S_IDLE) && (operation_i == OP_PIXEL))
    else $error("division started for a non-pixel word");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV)) else $error("quotient arrived outside divide");
  a_out_from_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_PACK))
    else $error("result word raised outside pack");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("second word taken while busy");

endmodule

### rtl/gbp_div.sv
// Bit-serial restoring divider: (dividend << 16) / divisor, dividend < divisor.
module gbp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbp_pkg::gbp_div_req_t       req_i,
  output logic                        done_o,
  output logic [gbp_pkg::QUO_W-1:0]   quot_o
);
  import gbp_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BW_W-1:0]  rem_q, dvs_q;
  logic [QUO_W-1:0] quot_q;
  logic [BW_W:0]    rem2, rem_sub;
  logic             fits;

  always_comb begin
    rem2    = {rem_q, 1'b0};
    fits    = rem2 >= {1'b0, dvs_q};
    rem_sub = rem2 - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // done pulses the cycle after the last quotient bit
      done_q <= !req_i.start && busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift one bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= fits ? rem_sub[BW_W-1:0] : rem2[BW_W-1:0];
      quot_q <= {quot_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");

endmodule

### tb/gbp_pixel_checker.sv
// Word checker for the gradient beam pixel generator: beam tracking, color prediction, compare.
module gbp_pixel_checker #(
  parameter int MAX_TRACK = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [gbp_pkg::OP_W-1:0]      operation_i,
  input  logic [gbp_pkg::COL_W-1:0]     column_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [gbp_pkg::PIX_W-1:0]     pixel_value_i,
  input  logic                          inside_beam_i,
  input  logic                          cfg_we_i,
  input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gbp_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            mismatch_count_o,
  output int                            words_due_o
);
  import gbp_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             in_beam;
  } beam_word_t;

  // register copies
  logic [TRK_W-1:0]   track_len;
  logic [BW_W-1:0]    beam_len;
  logic [STEP_W-1:0]  step_len;
  logic               packing_888;
  logic [SHIFT_W-1:0] red_sh, green_sh, blue_sh;
  int                 beam_origin;

  beam_word_t pixel_words_due[$];
  int         mismatches;
  int         lines_printed;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] seen);
    mismatches++;
    if (lines_printed < 200) begin
      lines_printed++;
      $display("[%0t] mismatch %s: expected %h, got %h", $realtime, what, want, seen);
    end
  endtask

  // t = 1 - offset/beam in Q1.16, then the two-segment ramp and packing
  function automatic logic [PIX_W-1:0] shade_pixel(int unsigned offset);
    longint unsigned quo;
    int unsigned     t, u, r, g, b;
    quo = offset;
    quo = (quo << 16) / beam_len;
    t = 32'd65536 - 32'(quo);
    if (t < 32'd32768) begin
      r = 0;
      g = G_LO_BASE + ((t * G_LO_SLOPE) >> 16);
      b = B_LO_BASE + ((t * B_LO_SLOPE) >> 16);
    end else begin
      u = 2 * t - 32'd65536;
      r = (u * R_HI_SLOPE) >> 16;
      g = G_HI_BASE + ((u * G_HI_SLOPE) >> 16);
      b = B_HI;
    end
    if (!packing_888) begin
      r = (r >> 3) & 'h1f;
      g = (g >> 2) & 'h3f;
      b = (b >> 3) & 'h1f;
    end
    return (PIX_W'(r) << red_sh) | (PIX_W'(g) << green_sh) | (PIX_W'(b) << blue_sh);
  endfunction

  // expected word for one accepted item; moves the beam for ticks and restarts
  function automatic beam_word_t predict_word(logic [OP_W-1:0] op, logic [COL_W-1:0] col);
    beam_word_t w;
    int         trk, offset, nxt;
    w   = '0;
    trk = (int'(track_len) > MAX_TRACK) ? MAX_TRACK : int'(track_len);
    case (op)
      OP_PIXEL: begin
        offset = int'(col) - beam_origin;
        if (int'(col) < trk && offset >= 0 && offset < int'(beam_len)) begin
          w.pixel   = shade_pixel(offset);
          w.in_beam = 1'b1;
        end
      end
      OP_TICK: begin
        nxt = beam_origin + int'(step_len);
        if (nxt > trk) nxt = -int'(beam_len);
        beam_origin = nxt;
      end
      OP_RESTART: beam_origin = -int'(beam_len);
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    beam_word_t want;
    if (!rst_ni) begin
      track_len     = TRACK_RST;
      beam_len      = BW_RST;
      step_len      = STEP_RST;
      packing_888   = FORMAT_RST;
      red_sh        = RSHIFT_RST;
      green_sh      = GSHIFT_RST;
      blue_sh       = BSHIFT_RST;
      beam_origin   = -int'(BW_RST);
      mismatches    = 0;
      lines_printed = 0;
      pixel_words_due.delete();
      words_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TRACK:  track_len   = cfg_data_i[TRK_W-1:0];
          CFG_BEAM:   beam_len    = cfg_data_i[BW_W-1:0];
          CFG_STEP:   step_len    = cfg_data_i[STEP_W-1:0];
          CFG_FORMAT: packing_888 = cfg_data_i[0];
          CFG_RSHIFT: red_sh      = cfg_data_i[SHIFT_W-1:0];
          CFG_GSHIFT: green_sh    = cfg_data_i[SHIFT_W-1:0];
          CFG_BSHIFT: blue_sh     = cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      // result side first: a word leaving now belongs to an older item
      if (out_valid_i && out_ready_i) begin
        if (pixel_words_due.size() == 0) begin
          report_mismatch("unexpected word", '0, pixel_value_i);
        end else begin
          want = pixel_words_due.pop_front();
          if (pixel_value_i !== want.pixel)
            report_mismatch("pixel_value", want.pixel, pixel_value_i);
          if (inside_beam_i !== want.in_beam)
            report_mismatch("inside_beam", PIX_W'(want.in_beam), PIX_W'(inside_beam_i));
        end
      end
      if (in_valid_i && in_ready_i)
        pixel_words_due.push_back(predict_word(operation_i, column_i));
      words_due_o <= pixel_words_due.size();
    end
  end

endmodule

### tb/tb_gradient_beam_progress_pixel_gen.sv
// Top level testbench of the gradient beam progress pixel generator.
module tb_gradient_beam_progress_pixel_gen;
  import gbp_pkg::*;

  localparam int TRACK_CAP  = 4096;
  // cycles without any accepted word before the run is called hung; in-beam
  // pixels, random stall runs and register phases stay far below
  localparam int HANG_LIMIT = 4000;
  // drain margin at the end, longer than an in-beam pixel takes
  localparam int TAIL_WAIT  = 40;
  // code 3 has no meaning in the block; it must be swallowed with a zero word
  localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OP_W-1:0]      operation_i;
  logic [COL_W-1:0]     column_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     pixel_value_o;
  logic                 inside_beam_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int mismatch_count;
  int words_due;
  int sender_idle_pct;
  int recv_stall_pct = 0;
  int quiet_cycles;

  gradient_beam_progress_pixel_gen #(
    .MAX_TRACK(TRACK_CAP)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .column_i      (column_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .inside_beam_o (inside_beam_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // the checker sees exactly what the block sees and predicts from that alone
  gbp_pixel_checker #(
    .MAX_TRACK(TRACK_CAP)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .operation_i      (operation_i),
    .column_i         (column_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_value_i    (pixel_value_o),
    .inside_beam_i    (inside_beam_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .words_due_o      (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: ready is redrawn every falling edge. With a stall share of zero
  // it stays high, so whole phases run without back-pressure.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hang guard: any accepted word on either channel clears the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("** gradient_beam_progress_pixel_gen: FAILED **");
        $finish;
      end
    end
  end

  // One input word. Called at a falling edge, returns at a falling edge.
  // Idle cycles come first, drawn per cycle so their runs vary in length and
  // land on every stage of the divider.
  task automatic send_word(logic [OP_W-1:0] op, logic [COL_W-1:0] col);
    in_valid_i = 1'b0;
    while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clk_i);
    in_valid_i  = 1'b1;
    operation_i = op;
    column_i    = col;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // every item returns exactly one word, so an empty list means the block is idle
  task automatic wait_drained();
    while (words_due != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_setting(int trk, int bw, int stp, bit fmt, int rs, int gs, int bs);
    write_reg(CFG_TRACK,  CFG_W'(trk));
    write_reg(CFG_BEAM,   CFG_W'(bw));
    write_reg(CFG_STEP,   CFG_W'(stp));
    write_reg(CFG_FORMAT, CFG_W'(fmt));
    write_reg(CFG_RSHIFT, CFG_W'(rs));
    write_reg(CFG_GSHIFT, CFG_W'(gs));
    write_reg(CFG_BSHIFT, CFG_W'(bs));
  endtask

  // Random traffic. Mostly pixel requests aimed at the live track so the beam
  // gets hit; ticks are frequent enough that the beam sweeps and wraps.
  task automatic run_traffic(int count, int trk);
    int               pick, hi;
    logic [OP_W-1:0]  op;
    logic [COL_W-1:0] col;
    hi = (trk > 4079) ? 4095 : trk + 16;
    send_word(OP_RESTART, COL_W'($urandom));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 68)      op = OP_PIXEL;
      else if (pick < 92) op = OP_TICK;
      else if (pick < 97) op = OP_RESTART;
      else                op = OP_UNUSED;
      if ($urandom_range(0, 99) < 75) col = COL_W'($urandom_range(0, hi));
      else                            col = COL_W'($urandom_range(0, 4095));
      send_word(op, col);
    end
  endtask

  initial begin
    int trk, bw;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = OP_PIXEL;
    column_i        = '0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_TRACK;
    cfg_data_i      = '0;
    sender_idle_pct = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset register values: beam 180 wide starting at -180.
    send_word(OP_RESTART, 12'd0);
    send_word(OP_PIXEL, 12'd0);           // one past the beam end
    repeat (10) send_word(OP_TICK, 12'hfff);  // beam start now at 0
    send_word(OP_PIXEL, 12'd0);           // t = 1.0, top of the ramp
    send_word(OP_PIXEL, 12'd89);          // just above the segment split
    send_word(OP_PIXEL, 12'd90);          // exactly at the split
    send_word(OP_PIXEL, 12'd179);         // last beam column, low segment
    send_word(OP_PIXEL, 12'd180);         // first column past the beam
    send_word(OP_PIXEL, 12'd4095);        // beyond the track
    send_word(OP_UNUSED, 12'd4095);
    send_word(OP_TICK, 12'd0);
    send_word(OP_PIXEL, 12'd18);          // follows the moved beam
    send_word(OP_RESTART, 12'd0);
    send_word(OP_PIXEL, 12'd0);
    wait_drained();
    write_reg(CFG_NONE, 13'h1fff);        // no register there, must change nothing

    // Register phases, each with its own idling mix:
    // none, sender idle, receiver stall, both.
    for (int k = 0; k < 8; k++) begin
      case (k % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      wait_drained();
      case (k)
        // narrow beam, 5:6:5 packing
        0: begin trk = 200;  bw = 20;   load_setting(trk, bw, 2, 1'b0, 11, 5, 0); end
        // widest legal track and beam, coarse steps
        1: begin trk = 4096; bw = 4096; load_setting(trk, bw, 136, 1'b1, 24, 16, 8); end
        // all-ones track, beam and step: track above the cap, top shifts lose bits
        2: begin trk = 8191; bw = 8191; load_setting(trk, bw, 255, 1'b0, 31, 0, 27); end
        // zero beam width: nothing inside, no division; zero step
        3: begin trk = 1;    bw = 0;    load_setting(trk, bw, 0, 1'b1, 0, 0, 31); end
        default: begin
          trk = $urandom_range(64, 700);
          bw  = $urandom_range(20, trk);
          load_setting(trk, bw, $urandom_range(2, 136), 1'($urandom),
                       $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        end
      endcase
      run_traffic((k == 3) ? 40 : 125, trk);
    end

    sender_idle_pct = 0;
    wait_drained();
    repeat (TAIL_WAIT) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("** gradient_beam_progress_pixel_gen: PASSED **");
    end else begin
      $display("** gradient_beam_progress_pixel_gen: FAILED **");
    end
    $finish;
  end

endmodule

### gradient_beam_progress_pixel_gen.f
rtl/gbp_pkg.sv
rtl/gbp_div.sv
rtl/gradient_beam_progress_pixel_gen.sv
tb/gbp_pixel_checker.sv
tb/tb_gradient_beam_progress_pixel_gen.sv
